FILE: rtl/core/dobd_pkg.sv
// ----------------------------------------------------------------------------
// Date offset package
// Shared constants, types and calendar helper functions for the date offset
// block.
// ----------------------------------------------------------------------------
package dobd_pkg;

   localparam int OFFSET_BITS_DEFAULT = 20;
   localparam int YEAR_BITS_DEFAULT   = 14;

   // Direction of the move carried by the command field of an item.
   localparam logic CMD_FORWARD  = 1'b0;
   localparam logic CMD_BACKWARD = 1'b1;

   // Length of the Gregorian leap cycle in years.
   localparam logic [8:0] CYCLE_YEARS = 9'd400;
   localparam logic [8:0] CYCLE_LAST  = 9'd399;
   localparam logic [8:0] CENTURY_1   = 9'd100;
   localparam logic [8:0] CENTURY_2   = 9'd200;
   localparam logic [8:0] CENTURY_3   = 9'd300;

   localparam logic [8:0] DAYS_COMMON_YEAR = 9'd365;
   localparam logic [8:0] DAYS_LEAP_YEAR   = 9'd366;

   localparam logic [3:0] MONTH_JAN = 4'd1;
   localparam logic [3:0] MONTH_FEB = 4'd2;
   localparam logic [3:0] MONTH_DEC = 4'd12;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_INVALID = 2'd1,
      STATUS_RANGE   = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_CHECK,
      ST_FWD_YEAR,
      ST_BACK_YEAR,
      ST_MONTH,
      ST_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic reduce;
      logic check;
      logic mark_invalid;
      logic mark_range;
      logic fwd_year;
      logic back_year;
      logic month_step;
      logic publish;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic reduce_done;
      logic start_bad;
      logic backward;
      logic back_in_year;
      logic fwd_done;
      logic fwd_range;
      logic back_done;
      logic back_range;
      logic month_done;
   } stat_type;

   // A year is a leap year when it is divisible by 4, except for the century
   // years that are not divisible by 400. The position within the 400 year
   // cycle carries the century information.
   function automatic logic is_leap(input logic [1:0] year_low, input logic [8:0] cycle_pos);
      is_leap = (year_low == 2'd0) && (cycle_pos != CENTURY_1) &&
                (cycle_pos != CENTURY_2) && (cycle_pos != CENTURY_3);
   endfunction

   function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      unique case (month)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
         4'd2:                                      len = leap ? 5'd29 : 5'd28;
         default:                                   len = 5'd0;
      endcase
      month_days = len;
   endfunction

   // Days in the months before the given month of a common year.
   function automatic logic [8:0] days_before(input logic [3:0] month);
      logic [8:0] days;
      unique case (month)
         4'd1:    days = 9'd0;
         4'd2:    days = 9'd31;
         4'd3:    days = 9'd59;
         4'd4:    days = 9'd90;
         4'd5:    days = 9'd120;
         4'd6:    days = 9'd151;
         4'd7:    days = 9'd181;
         4'd8:    days = 9'd212;
         4'd9:    days = 9'd243;
         4'd10:   days = 9'd273;
         4'd11:   days = 9'd304;
         4'd12:   days = 9'd334;
         default: days = 9'd0;
      endcase
      days_before = days;
   endfunction

endpackage

FILE: rtl/core/dobd_datapath.sv
// ----------------------------------------------------------------------------
// Date offset datapath
// Holds the working date, the remaining day count and the result register,
// and steps them under command of the controller.
// ----------------------------------------------------------------------------
module dobd_datapath import dobd_pkg::*; #(
   parameter int YEAR_BITS   = YEAR_BITS_DEFAULT,
   parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output stat_type               stat,
   input  logic                   req_command,
   input  logic [YEAR_BITS-1:0]   req_start_year,
   input  logic [3:0]             req_start_month,
   input  logic [4:0]             req_start_day,
   input  logic [OFFSET_BITS-1:0] req_day_offset,
   output logic [YEAR_BITS-1:0]   rsp_result_year,
   output logic [3:0]             rsp_result_month,
   output logic [4:0]             rsp_result_day,
   output logic [1:0]             rsp_status
);

   localparam int REM_W = OFFSET_BITS + 2;
   localparam int WORK_W = (YEAR_BITS > 9) ? YEAR_BITS : 9;
   localparam logic [YEAR_BITS-1:0] YEAR_MAX = {YEAR_BITS{1'b1}};
   localparam logic [YEAR_BITS-1:0] YEAR_ONE = YEAR_BITS'(1);

   logic                   back_ff;
   logic [YEAR_BITS-1:0]   year_ff;
   logic [3:0]             month_ff;
   logic [4:0]             day_ff;
   logic [OFFSET_BITS-1:0] off_ff;
   logic [WORK_W-1:0]      work_ff;
   logic [8:0]             cycle_ff;
   logic [REM_W-1:0]       rem_ff;
   status_type             code_ff;
   logic [YEAR_BITS-1:0]   out_year_ff;
   logic [3:0]             out_month_ff;
   logic [4:0]             out_day_ff;
   status_type             out_status_ff;

   logic                 leap_cur;
   logic                 leap_prev;
   logic [8:0]           ylen_cur;
   logic [8:0]           ylen_prev;
   logic [YEAR_BITS-1:0] year_prev;
   logic [8:0]           cycle_prev;
   logic [8:0]           cycle_next;
   logic [4:0]           mlen;
   logic [REM_W-1:0]     doy;
   logic [REM_W-1:0]     off_ext;

   always_comb begin
      leap_cur   = is_leap(year_ff[1:0], cycle_ff);
      ylen_cur   = leap_cur ? DAYS_LEAP_YEAR : DAYS_COMMON_YEAR;
      year_prev  = year_ff - YEAR_ONE;
      cycle_prev = (cycle_ff == 9'd0) ? CYCLE_LAST : cycle_ff - 9'd1;
      cycle_next = (cycle_ff == CYCLE_LAST) ? 9'd0 : cycle_ff + 9'd1;
      leap_prev  = is_leap(year_prev[1:0], cycle_prev);
      ylen_prev  = leap_prev ? DAYS_LEAP_YEAR : DAYS_COMMON_YEAR;
      mlen       = month_days(month_ff, leap_cur);
      off_ext    = REM_W'(off_ff);
      // Zero-based day of the year of the start date.
      doy = REM_W'(days_before(month_ff)) + REM_W'(day_ff) - REM_W'(1) +
            REM_W'((month_ff > MONTH_FEB) && leap_cur);

      stat.reduce_done  = work_ff < WORK_W'(CYCLE_YEARS);
      stat.start_bad    = (year_ff == '0) || (month_ff == 4'd0) || (month_ff > MONTH_DEC) ||
                          (day_ff == 5'd0) || (day_ff > mlen);
      stat.backward     = back_ff;
      stat.back_in_year = off_ext <= doy;
      stat.fwd_done     = rem_ff < REM_W'(ylen_cur);
      stat.fwd_range    = (rem_ff >= REM_W'(ylen_cur)) && (year_ff == YEAR_MAX);
      stat.back_done    = rem_ff <= REM_W'(ylen_prev);
      stat.back_range   = year_ff == YEAR_ONE;
      stat.month_done   = rem_ff < REM_W'(mlen);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         back_ff  <= req_command;
         year_ff  <= req_start_year;
         month_ff <= req_start_month;
         day_ff   <= req_start_day;
         off_ff   <= req_day_offset;
         work_ff  <= WORK_W'(req_start_year);
         code_ff  <= STATUS_OK;
      end
      if (cmd.reduce) begin
         if (!stat.reduce_done) begin
            work_ff <= work_ff - WORK_W'(CYCLE_YEARS);
         end else begin
            cycle_ff <= work_ff[8:0];
         end
      end
      if (cmd.check) begin
         month_ff <= MONTH_JAN;
         if (back_ff) begin
            rem_ff <= stat.back_in_year ? doy - off_ext : off_ext - doy;
         end else begin
            rem_ff <= doy + off_ext;
         end
      end
      if (cmd.mark_invalid) begin
         code_ff <= STATUS_INVALID;
      end
      if (cmd.mark_range) begin
         code_ff <= STATUS_RANGE;
      end
      if (cmd.fwd_year) begin
         rem_ff   <= rem_ff - REM_W'(ylen_cur);
         year_ff  <= year_ff + YEAR_ONE;
         cycle_ff <= cycle_next;
      end
      if (cmd.back_year) begin
         year_ff  <= year_prev;
         cycle_ff <= cycle_prev;
         // The remaining count is a deficit below January 1 until it fits.
         rem_ff   <= stat.back_done ? REM_W'(ylen_prev) - rem_ff : rem_ff - REM_W'(ylen_prev);
      end
      if (cmd.month_step) begin
         rem_ff   <= rem_ff - REM_W'(mlen);
         month_ff <= month_ff + 4'd1;
      end
      if (cmd.publish) begin
         out_status_ff <= code_ff;
         if (code_ff == STATUS_OK) begin
            out_year_ff  <= year_ff;
            out_month_ff <= month_ff;
            out_day_ff   <= rem_ff[4:0] + 5'd1;
         end else begin
            out_year_ff  <= '0;
            out_month_ff <= '0;
            out_day_ff   <= '0;
         end
      end
   end

   assign rsp_result_year  = out_year_ff;
   assign rsp_result_month = out_month_ff;
   assign rsp_result_day   = out_day_ff;
   assign rsp_status       = out_status_ff;

   // A forward year step never runs past the last representable year.
   a_fwd_year_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.fwd_year |-> (year_ff != YEAR_MAX))
      else $error("forward year step at the last year");

   // The month walk always stops within December.
   a_month_walk_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.month_step |-> (month_ff < MONTH_DEC))
      else $error("month walk ran past December");

   // A backward year step never goes below year one.
   a_back_year_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.back_year |-> (year_ff != YEAR_ONE))
      else $error("backward year step below year one");

endmodule

FILE: rtl/core/dobd_ctrl.sv
// ----------------------------------------------------------------------------
// Date offset controller
// Sequences the reduction, validation, year walk and month walk of one item,
// and owns the handshake of both channels.
// ----------------------------------------------------------------------------
module dobd_ctrl import dobd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      out_free  = !rsp_valid_ff || !rsp_stall;
      req_stall = (state_ff != ST_IDLE);
      cmd       = '0;
      state_in  = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            cmd.reduce = 1'b1;
            if (stat.reduce_done) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            priority if (stat.start_bad) begin
               cmd.mark_invalid = 1'b1;
               state_in         = ST_DONE;
            end else if (stat.backward) begin
               state_in = stat.back_in_year ? ST_MONTH : ST_BACK_YEAR;
            end else begin
               state_in = ST_FWD_YEAR;
            end
         end
         ST_FWD_YEAR: begin
            priority if (stat.fwd_range) begin
               cmd.mark_range = 1'b1;
               state_in       = ST_DONE;
            end else if (stat.fwd_done) begin
               state_in = ST_MONTH;
            end else begin
               cmd.fwd_year = 1'b1;
            end
         end
         ST_BACK_YEAR: begin
            if (stat.back_range) begin
               cmd.mark_range = 1'b1;
               state_in       = ST_DONE;
            end else begin
               cmd.back_year = 1'b1;
               if (stat.back_done) begin
                  state_in = ST_MONTH;
               end
            end
         end
         ST_MONTH: begin
            if (stat.month_done) begin
               state_in = ST_DONE;
            end else begin
               cmd.month_step = 1'b1;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.publish || (rsp_valid_ff && rsp_stall);
   end

   assign rsp_valid = rsp_valid_ff;

   // An accepted item always starts with the leap cycle reduction.
   a_accept_starts_reduce: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_REDUCE))
      else $error("accepted item did not enter reduction");

   // A result is never written over one that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result overwritten while stalled");

   // A new result appears only after the controller finished an item.
   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("result raised outside the finishing state");

endmodule

FILE: rtl/core/date_offset_by_days.sv
// ----------------------------------------------------------------------------
// Date offset by days
// The time from acceptance to a valid result grows with the number of leap
// cycle subtractions, the years crossed and the months walked; the year walk
// steps one year per cycle.
// Throughput: one item at a time; the next is accepted once the previous
// result sits in the output register. Reset is synchronous, active high,
// and clears the controller state and the result valid flag.
// ----------------------------------------------------------------------------
module date_offset_by_days import dobd_pkg::*; #(
   parameter int YEAR_BITS   = YEAR_BITS_DEFAULT,
   parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_command,
   input  logic [YEAR_BITS-1:0]   req_start_year,
   input  logic [3:0]             req_start_month,
   input  logic [4:0]             req_start_day,
   input  logic [OFFSET_BITS-1:0] req_day_offset,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [YEAR_BITS-1:0]   rsp_result_year,
   output logic [3:0]             rsp_result_month,
   output logic [4:0]             rsp_result_day,
   output logic [1:0]             rsp_status
);

   // The controller and the datapath talk only through these two bundles.
   // An item is taken in only while the controller is idle. Its year is
   // first reduced modulo 400 by repeated subtraction, which gives the
   // position in the leap cycle that the leap rule needs. The start date is
   // then validated and turned into a day of the year. A forward move walks
   // whole years and then months; a backward move that leaves the start year
   // walks back whole years until the remaining deficit fits in one.
   // The finished date is copied into the output register, so the next item
   // may be accepted while that result still waits to be taken.
   cmd_type  cmd;
   stat_type stat;

   dobd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   dobd_datapath #(
      .YEAR_BITS   (YEAR_BITS),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_command      (req_command),
      .req_start_year   (req_start_year),
      .req_start_month  (req_start_month),
      .req_start_day    (req_start_day),
      .req_day_offset   (req_day_offset),
      .rsp_result_year  (rsp_result_year),
      .rsp_result_month (rsp_result_month),
      .rsp_result_day   (rsp_result_day),
      .rsp_status       (rsp_status)
   );

endmodule
